[design/iprl_pkg.sv]
// iprl_pkg: shared types and constants for the ipv6 range lookup block
// holds opcodes, controller states and the controller/datapath command and status structs
// no dependencies

package iprl_pkg;

  // field widths fixed by the transaction format
  localparam int IDX_W  = 20;
  localparam int ADDR_W = 64;
  localparam int PFX_W  = 16;
  localparam int OP_W   = 2;

  localparam int PFX_DEPTH = 1 << PFX_W;

  typedef enum logic [OP_W-1:0] {
    OP_WR_PREFIX = 2'd0,
    OP_WR_END    = 2'd1,
    OP_QUERY     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_ISSUE,
    S_COMPARE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_prefix;
    logic wr_end;
    logic query;
    logic load_range;
    logic issue_probe;
    logic update;
  } iprl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic single;
    logic in_range;
    logic reaches;
    logic mid_zero;
  } iprl_sts_t;

endpackage

[design/iprl_ctrl.sv]
// iprl_ctrl: controller state machine for the ipv6 range lookup
// sequences prefix read, binary search probes and the result strobe
// depends on iprl_pkg

module iprl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [iprl_pkg::OP_W-1:0]   in_opcode,
  input  iprl_pkg::iprl_sts_t         sts,
  output iprl_pkg::iprl_cmd_t         cmd,
  output logic                        busy,
  output logic                        out_valid
);

  iprl_pkg::state_t state_r;
  iprl_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iprl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iprl_pkg::S_IDLE: begin
        if (start && (iprl_pkg::opcode_t'(in_opcode) == iprl_pkg::OP_QUERY)) begin
          state_nxt = iprl_pkg::S_PREFIX;
        end
      end
      iprl_pkg::S_PREFIX: begin
        state_nxt = sts.single ? iprl_pkg::S_DONE : iprl_pkg::S_ISSUE;
      end
      iprl_pkg::S_ISSUE: begin
        state_nxt = sts.in_range ? iprl_pkg::S_COMPARE : iprl_pkg::S_DONE;
      end
      iprl_pkg::S_COMPARE: begin
        if (sts.reaches && sts.mid_zero) begin
          state_nxt = iprl_pkg::S_DONE;
        end else begin
          state_nxt = iprl_pkg::S_ISSUE;
        end
      end
      iprl_pkg::S_DONE: begin
        state_nxt = iprl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = iprl_pkg::S_IDLE;
      end
    endcase
  end

  // command and handshake outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      iprl_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (iprl_pkg::opcode_t'(in_opcode))
            iprl_pkg::OP_WR_PREFIX: cmd.wr_prefix = 1'b1;
            iprl_pkg::OP_WR_END:    cmd.wr_end    = 1'b1;
            iprl_pkg::OP_QUERY:     cmd.query     = 1'b1;
            default: ;
          endcase
        end
      end
      iprl_pkg::S_PREFIX: begin
        cmd.load_range = 1'b1;
      end
      iprl_pkg::S_ISSUE: begin
        cmd.issue_probe = sts.in_range;
      end
      iprl_pkg::S_COMPARE: begin
        cmd.update = 1'b1;
      end
      iprl_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[design/iprl_dp.sv]
// iprl_dp: datapath of the ipv6 range lookup
// holds the prefix and record memories, search bounds, probe compare and result registers
// depends on iprl_pkg

module iprl_dp #(
  parameter int RECORD_COUNT = 1048576
) (
  input  logic                          clk,
  input  logic [iprl_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [iprl_pkg::IDX_W-1:0]    in_range_first,
  input  logic [iprl_pkg::IDX_W-1:0]    in_range_last,
  input  logic [iprl_pkg::ADDR_W-1:0]   in_addr_high,
  input  logic [iprl_pkg::ADDR_W-1:0]   in_addr_low,
  input  iprl_pkg::iprl_cmd_t           cmd,
  output iprl_pkg::iprl_sts_t           sts,
  output logic [iprl_pkg::IDX_W-1:0]    out_record_index,
  output logic                          out_found
);

  localparam int IW = iprl_pkg::IDX_W;
  localparam int AW = iprl_pkg::ADDR_W;
  localparam int PW = iprl_pkg::PFX_W;
  localparam int RAW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;

  // memories
  logic [2*IW-1:0] pfx_mem_r [iprl_pkg::PFX_DEPTH];
  logic [2*AW-1:0] rec_mem_r [RECORD_COUNT];

  logic [2*IW-1:0] pfx_q_r;
  logic [2*AW-1:0] rec_q_r;

  // query address and search state
  logic [AW-1:0] ah_r;
  logic [AW-1:0] al_r;
  logic [IW:0]   lo_r;
  logic [IW-1:0] hi_r;
  logic [IW-1:0] mid_r;
  logic          oob_r;
  logic [IW-1:0] ans_r;
  logic          hit_r;

  logic [IW-1:0] pfx_first;
  logic [IW-1:0] pfx_last;
  logic          pfx_ok;
  logic          rec_ok;
  logic [IW+1:0] bound_sum;
  logic [IW-1:0] mid_nxt;
  logic          mid_oob;
  logic          reaches;

  assign pfx_first = pfx_q_r[2*IW-1:IW];
  assign pfx_last  = pfx_q_r[IW-1:0];
  assign pfx_ok    = (in_slot_index[IW-1:PW] == '0);
  assign rec_ok    = (32'(in_slot_index) < 32'(RECORD_COUNT));

  // midpoint of the current bounds
  assign bound_sum = {1'b0, lo_r} + {2'b00, hi_r};
  assign mid_nxt   = bound_sum[IW:1];
  assign mid_oob   = (32'(mid_nxt) >= 32'(RECORD_COUNT));

  // probed end at or above the address; a probe past the table sees zero
  always_comb begin
    if (oob_r) begin
      reaches = (ah_r == '0) && (al_r == '0);
    end else begin
      reaches = (rec_q_r >= {ah_r, al_r});
    end
  end

  // prefix table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_prefix && pfx_ok) begin
      pfx_mem_r[in_slot_index[PW-1:0]] <= {in_range_first, in_range_last};
    end
    if (cmd.query) begin
      pfx_q_r <= pfx_mem_r[in_addr_high[AW-1 -: PW]];
    end
  end

  // record table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_end && rec_ok) begin
      rec_mem_r[RAW'(in_slot_index)] <= {in_addr_high, in_addr_low};
    end
    if (cmd.issue_probe) begin
      rec_q_r <= rec_mem_r[RAW'(mid_nxt)];
    end
  end

  // search bounds and answer
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      ah_r <= in_addr_high;
      al_r <= in_addr_low;
    end
    if (cmd.load_range) begin
      lo_r <= {1'b0, pfx_first};
      hi_r <= pfx_last;
      if (pfx_first == pfx_last) begin
        ans_r <= pfx_first;
        hit_r <= 1'b1;
      end else begin
        ans_r <= '0;
        hit_r <= 1'b0;
      end
    end
    if (cmd.issue_probe) begin
      mid_r <= mid_nxt;
      oob_r <= mid_oob;
    end
    if (cmd.update) begin
      if (reaches) begin
        ans_r <= mid_r;
        hit_r <= 1'b1;
        hi_r  <= mid_r - 1'b1;
      end else begin
        lo_r  <= {1'b0, mid_r} + 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.single   = (pfx_first == pfx_last);
    sts.in_range = (lo_r <= {1'b0, hi_r});
    sts.reaches  = reaches;
    sts.mid_zero = (mid_r == '0);
  end

  assign out_record_index = ans_r;
  assign out_found        = hit_r;

endmodule

[design/ipv6_range_lookup_top.sv]
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// input     | in_opcode, in_slot_index, in_range_*,   | taken when start && !busy
//           | in_addr_high, in_addr_low               |
// result    | out_record_index, out_found             | out_valid for one cycle
//
// writes of either table leave busy low
// a query reads the prefix table, then runs up to 21 binary search probes for a full range
// the search stops early on index zero; no probe is made when first equals last
// each probe is one registered read of the record memory followed by a 128-bit compare
// reset is synchronous active low and returns the controller to idle; tables keep no reset
// the receiver cannot stall: each result is presented for exactly one cycle
//
// ipv6_range_lookup_top: top level joining controller and datapath
// depends on iprl_pkg, iprl_ctrl, iprl_dp

module ipv6_range_lookup_top #(
  parameter int RECORD_COUNT = 1048576
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [iprl_pkg::OP_W-1:0]     in_opcode,
  input  logic [iprl_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [iprl_pkg::IDX_W-1:0]    in_range_first,
  input  logic [iprl_pkg::IDX_W-1:0]    in_range_last,
  input  logic [iprl_pkg::ADDR_W-1:0]   in_addr_high,
  input  logic [iprl_pkg::ADDR_W-1:0]   in_addr_low,
  output logic                          out_valid,
  output logic [iprl_pkg::IDX_W-1:0]    out_record_index,
  output logic                          out_found
);

  iprl_pkg::iprl_cmd_t cmd;
  iprl_pkg::iprl_sts_t sts;

  // controller
  iprl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath
  iprl_dp #(
    .RECORD_COUNT (RECORD_COUNT)
  ) u_dp (
    .clk              (clk),
    .in_slot_index    (in_slot_index),
    .in_range_first   (in_range_first),
    .in_range_last    (in_range_last),
    .in_addr_high     (in_addr_high),
    .in_addr_low      (in_addr_low),
    .cmd              (cmd),
    .sts              (sts),
    .out_record_index (out_record_index),
    .out_found        (out_found)
  );

`ifndef SYNTHESIS
  // a table write never holds the block busy
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_prefix || cmd.wr_end) |=> !busy)
    else $error("busy after a table write transaction");

  // a query transaction always starts a search
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.query |=> busy)
    else $error("query transaction did not start a search");

  // a result only comes out of a running query and ends it
  a_result_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a query");

  a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after the result");

  // probes are issued only within the search bounds
  a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_probe |-> sts.in_range)
    else $error("probe issued with empty bounds");
`endif

endmodule
